@@ src/register_vm_execute_core_top_macros.svh @@
// assertion macros for the execute core
`ifndef REGISTER_VM_EXECUTE_CORE_TOP_MACROS_SVH
`define REGISTER_VM_EXECUTE_CORE_TOP_MACROS_SVH

`define RVM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define RVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/rvm_exec_pkg.sv @@
package rvm_exec_pkg;

  localparam int NUM_REGS = 32;
  localparam int REG_W = 64;
  localparam int IDX_W = 5;
  localparam int ADDR_W = $clog2(NUM_REGS);
  localparam logic [IDX_W-1:0] IP_REG = 5'd17;
  localparam logic [IDX_W-1:0] CMP_REG = 5'd21;
  localparam logic CFG_PROGRAM_SIZE = 1'b0;
  localparam logic CFG_START_ADDRESS = 1'b1;

  typedef enum logic [4:0] {
    ACT_MOV = 5'd0, ACT_AND = 5'd1, ACT_OR = 5'd2, ACT_XOR = 5'd3,
    ACT_LT = 5'd4, ACT_MT = 5'd5, ACT_LET = 5'd6, ACT_MET = 5'd7,
    ACT_ET = 5'd8, ACT_ADD = 5'd9, ACT_SUB = 5'd10, ACT_MUL = 5'd11,
    ACT_DIV = 5'd12, ACT_INC = 5'd13, ACT_DEC = 5'd14, ACT_CMP = 5'd15,
    ACT_JE = 5'd16, ACT_JZL = 5'd17, ACT_JZR = 5'd18, ACT_JZLE = 5'd19,
    ACT_JZRE = 5'd20, ACT_JNE = 5'd21, ACT_JMP = 5'd22, ACT_NOP = 5'd23
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ_A, ST_READ_B, ST_EXEC, ST_ITER, ST_WRITE, ST_OUT
  } state_t;

endpackage

@@ src/register_vm_execute_core_top.sv @@
// register vm execute core
// input channel: in_valid/in_stall carry one decoded instruction request
// (action, dest_reg, src_reg, jump_target, instr_length). output channel:
// out_valid/out_stall carry one result per request (written_value,
// next_address, branch_taken, finished).
// configuration: cfg_we with cfg_index 0 writes program_size, index 1 writes
// start_address and loads it into the instruction pointer. write only while idle.
// the register file is a memory with registered read, so the two operands
// are fetched in consecutive cycles.
// a request passes through the states read_a, read_b, exec, write and out;
// mul and div add an iter state after exec, in which they run on one shared
// shift/add unit one bit per cycle. out_valid is high in out. one request
// is in work at a time; in_stall is high from accept until the result has been
// taken, and the next request can be accepted in the cycle after that.
// reset clears program_size, the pointer and the compare value and starts a
// clearing pass over all 32 registers, during which in_stall stays high.
// while out_stall is high the result holds and no new request is taken.
module register_vm_execute_core_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  action,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src_reg,
  input  logic [63:0] jump_target,
  input  logic [3:0]  instr_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] written_value,
  output logic [63:0] next_address,
  output logic        branch_taken,
  output logic        finished,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rvm_exec_pkg::*;
`include "register_vm_execute_core_top_macros.svh"

  state_t state, state_next;

  logic [REG_W-1:0] mem [NUM_REGS];
  logic [REG_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [REG_W-1:0]  wdata;

  logic [REG_W-1:0] ip, cmpv, psize;
  logic [4:0] act;
  logic [IDX_W-1:0] dreg, sreg;
  logic [63:0] target;
  logic [REG_W-1:0] a, b, r;
  logic take;
  logic [1:0] kind;
  logic [ADDR_W:0] clr_cnt;
  logic clearing;
  // shared iterative unit
  logic [REG_W-1:0] acc, opq, rem;
  logic [6:0] it;
  logic [REG_W:0] rem_sh;
  logic [REG_W:0] diff;

  assign clearing = !clr_cnt[ADDR_W];
  assign rem_sh = {rem, opq[REG_W-1]};
  assign diff = rem_sh - {1'b0, b};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      clr_cnt <= '0;
      ip <= '0;
      cmpv <= '0;
      psize <= '0;
    end else begin
      state <= state_next;
      if (clearing) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) begin
        if (cfg_index == CFG_PROGRAM_SIZE) psize <= {32'd0, cfg_data};
        else ip <= {32'd0, cfg_data};
      end
      if (state == ST_IDLE && in_valid && !in_stall) ip <= ip + {60'd0, instr_length};
      if (state == ST_WRITE) begin
        if (kind == 2'd2) cmpv <= r;
        else if (kind == 2'd1 && dreg == CMP_REG) cmpv <= r;
        if (kind == 2'd3 && take) ip <= target;
        else if (kind == 2'd1 && dreg == IP_REG) ip <= r;
      end
    end
  end

  function automatic logic [REG_W-1:0] rd_sel(input logic [IDX_W-1:0] idx,
      input logic [REG_W-1:0] m, input logic [REG_W-1:0] ipv,
      input logic [REG_W-1:0] cv);
    logic [REG_W-1:0] v;
    v = m;
    if (idx == IP_REG) v = ipv;
    else if (idx == CMP_REG) v = cv;
    return v;
  endfunction

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        act <= action; dreg <= dest_reg; sreg <= src_reg; target <= jump_target;
      end
      ST_READ_B: a <= rd_sel(dreg, rdata, ip, cmpv);
      ST_EXEC: begin
        b <= rd_sel(sreg, rdata, ip, cmpv);
        acc <= '0; rem <= '0; it <= '0;
        opq <= a;
      end
      ST_ITER: begin
        it <= it + 1'b1;
        if (act == ACT_MUL) begin
          if (opq[0]) acc <= acc + (b << it[5:0]);
          opq <= opq >> 1;
        end else begin
          opq <= {opq[REG_W-2:0], !diff[REG_W]};
          rem <= diff[REG_W] ? rem_sh[REG_W-1:0] : diff[REG_W-1:0];
        end
      end
      default: ;
    endcase
  end

  logic c_zero, c_neg, c_pos;
  assign c_zero = cmpv == '0;
  assign c_neg = cmpv[REG_W-1];
  assign c_pos = !c_zero && !c_neg;

  always_comb begin
    r = '0; take = 1'b0; kind = 2'd0;
    case (act)
      ACT_MOV: begin r = b; kind = 2'd1; end
      ACT_AND: begin r = a & b; kind = 2'd1; end
      ACT_OR:  begin r = a | b; kind = 2'd1; end
      ACT_XOR: begin r = a ^ b; kind = 2'd1; end
      ACT_LT:  begin r = {63'd0, c_pos}; kind = 2'd2; end
      ACT_MT:  begin r = {63'd0, c_neg}; kind = 2'd2; end
      ACT_LET: begin r = {63'd0, !c_neg}; kind = 2'd2; end
      ACT_MET: begin r = {63'd0, c_neg || c_zero}; kind = 2'd2; end
      ACT_ET:  begin r = {63'd0, c_zero}; kind = 2'd2; end
      ACT_ADD: begin r = a + b; kind = 2'd1; end
      ACT_SUB: begin r = a - b; kind = 2'd1; end
      ACT_MUL: begin r = acc; kind = 2'd1; end
      ACT_DIV: begin r = (b == '0) ? '1 : opq; kind = 2'd1; end
      ACT_INC: begin r = a + 64'd1; kind = 2'd1; end
      ACT_DEC: begin r = a - 64'd1; kind = 2'd1; end
      ACT_CMP: begin r = a - b; kind = 2'd2; end
      ACT_JE:   begin take = c_zero; kind = 2'd3; end
      ACT_JZL:  begin take = c_pos; kind = 2'd3; end
      ACT_JZR:  begin take = c_neg; kind = 2'd3; end
      ACT_JZLE: begin take = !c_neg; kind = 2'd3; end
      ACT_JZRE: begin take = c_neg || c_zero; kind = 2'd3; end
      ACT_JNE:  begin take = !c_zero; kind = 2'd3; end
      ACT_JMP:  begin take = 1'b1; kind = 2'd3; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      written_value <= (kind == 2'd1 || kind == 2'd2) ? r : '0;
      branch_taken <= take;
    end
  end

  assign next_address = ip;
  assign finished = ip == psize;

  always_comb begin
    state_next = state;
    in_stall = 1'b1;
    out_valid = 1'b0;
    we = 1'b0;
    waddr = dreg[ADDR_W-1:0];
    wdata = r;
    raddr = dreg[ADDR_W-1:0];
    if (clearing) begin
      we = 1'b1;
      waddr = clr_cnt[ADDR_W-1:0];
      wdata = '0;
    end
    case (state)
      ST_IDLE: begin
        in_stall = clearing;
        if (in_valid && !clearing) state_next = ST_READ_A;
      end
      ST_READ_A: state_next = ST_READ_B;
      ST_READ_B: begin
        raddr = sreg[ADDR_W-1:0];
        state_next = ST_EXEC;
      end
      ST_EXEC: state_next = (act == ACT_MUL || act == ACT_DIV) ? ST_ITER : ST_WRITE;
      ST_ITER: if (it == 7'd63) state_next = ST_WRITE;
      ST_WRITE: begin
        we = kind == 2'd1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `RVM_ASSERT_IMP(a_no_accept_busy, (state != ST_IDLE), in_stall)
  `RVM_ASSERT_IMP(a_no_accept_clear, clearing, in_stall)
  `RVM_ASSERT_NEXT(a_out_hold, (out_valid && out_stall), (out_valid && $stable(written_value)))
  `RVM_ASSERT_NEXT(a_iter_bound, (state == ST_ITER && it == 7'd63), (state == ST_WRITE))

endmodule

@@ bench/register_vm_execute_core_checker.sv @@
module register_vm_execute_core_checker
  import rvm_exec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [4:0]  action,
  input  logic [4:0]  dest_reg,
  input  logic [4:0]  src_reg,
  input  logic [63:0] jump_target,
  input  logic [3:0]  instr_length,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] written_value,
  input  logic [63:0] next_address,
  input  logic        branch_taken,
  input  logic        finished,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] addr;
    logic        taken;
    logic        done;
  } step_result_t;

  logic [63:0] regs [NUM_REGS];
  logic [63:0] prog_size;
  step_result_t expected_q [$];

  assign pending = expected_q.size();

  function automatic logic [63:0] read_reg(logic [4:0] idx);
    if (idx < NUM_REGS) return regs[idx];
    return '0;
  endfunction

  task automatic execute_step();
    logic [63:0] a, b, c, r;
    logic zero, neg, pos, take;
    int kind;
    step_result_t e;
    r = '0;
    take = 1'b0;
    kind = 0;
    regs[IP_REG] = regs[IP_REG] + 64'(instr_length);
    a = read_reg(dest_reg);
    b = read_reg(src_reg);
    c = regs[CMP_REG];
    zero = (c == 0);
    neg = c[63];
    pos = !zero && !neg;
    case (action)
      ACT_MOV: begin r = b; kind = 1; end
      ACT_AND: begin r = a & b; kind = 1; end
      ACT_OR: begin r = a | b; kind = 1; end
      ACT_XOR: begin r = a ^ b; kind = 1; end
      ACT_LT: begin r = 64'(pos); kind = 2; end
      ACT_MT: begin r = 64'(neg); kind = 2; end
      ACT_LET: begin r = 64'(!neg); kind = 2; end
      ACT_MET: begin r = 64'(neg || zero); kind = 2; end
      ACT_ET: begin r = 64'(zero); kind = 2; end
      ACT_ADD: begin r = a + b; kind = 1; end
      ACT_SUB: begin r = a - b; kind = 1; end
      ACT_MUL: begin r = a * b; kind = 1; end
      ACT_DIV: begin r = (b == 0) ? '1 : a / b; kind = 1; end
      ACT_INC: begin r = a + 1; kind = 1; end
      ACT_DEC: begin r = a - 1; kind = 1; end
      ACT_CMP: begin r = a - b; kind = 2; end
      ACT_JE: begin take = zero; kind = 3; end
      ACT_JZL: begin take = pos; kind = 3; end
      ACT_JZR: begin take = neg; kind = 3; end
      ACT_JZLE: begin take = !neg; kind = 3; end
      ACT_JZRE: begin take = neg || zero; kind = 3; end
      ACT_JNE: begin take = !zero; kind = 3; end
      ACT_JMP: begin take = 1'b1; kind = 3; end
      default: ;
    endcase
    if (kind == 1) begin
      if (dest_reg < NUM_REGS) regs[dest_reg] = r;
    end else if (kind == 2) begin
      regs[CMP_REG] = r;
    end else if (kind == 3 && take) begin
      regs[IP_REG] = jump_target;
    end
    e.value = (kind == 1 || kind == 2) ? r : '0;
    e.addr = regs[IP_REG];
    e.taken = take;
    e.done = (regs[IP_REG] == prog_size);
    expected_q.push_back(e);
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    step_result_t e;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      prog_size = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_PROGRAM_SIZE) prog_size = {32'd0, cfg_data};
        else regs[IP_REG] = {32'd0, cfg_data};
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result value=%h addr=%h", $time,
                   written_value, next_address);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (written_value !== e.value) begin
            $display("%0t: written_value expected %h actual %h", $time,
                     e.value, written_value);
            errors++;
          end
          if (next_address !== e.addr) begin
            $display("%0t: next_address expected %h actual %h", $time,
                     e.addr, next_address);
            errors++;
          end
          if (branch_taken !== e.taken) begin
            $display("%0t: branch_taken expected %b actual %b", $time,
                     e.taken, branch_taken);
            errors++;
          end
          if (finished !== e.done) begin
            $display("%0t: finished expected %b actual %b", $time,
                     e.done, finished);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) execute_step();
    end
  end
endmodule

@@ bench/register_vm_execute_core_top_test.sv @@
module register_vm_execute_core_top_test;
  import rvm_exec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  action;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg;
  logic [63:0] jump_target;
  logic [3:0]  instr_length;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] written_value;
  logic [63:0] next_address;
  logic        branch_taken;
  logic        finished;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;
  int          results_seen;
  int          idle_cycles;
  int          requests_sent;
  int          stall_mode;

  register_vm_execute_core_top i_dut (.*);
  register_vm_execute_core_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern, mode changes now and then
  initial begin
    out_stall = 1'b0;
    stall_mode = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {1'b1, 63'd0};
      3: return 64'($urandom_range(0, 15));
      4: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send(logic [4:0] act, logic [4:0] d, logic [4:0] s,
                      logic [63:0] tgt, logic [3:0] len);
    in_valid <= 1'b1;
    action <= act;
    dest_reg <= d;
    src_reg <= s;
    jump_target <= tgt;
    instr_length <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic pause();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 8)) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_phase(int count);
    int burst;
    logic [4:0] act;
    logic [3:0] len;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        pause();
        burst = $urandom_range(1, 20);
      end
      burst--;
      act = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(24, 31))
                                          : 5'($urandom_range(0, 23));
      // mostly legal lengths, sometimes out of range
      len = ($urandom_range(0, 9) == 0) ? 4'($urandom()) : 4'($urandom_range(1, 9));
      if (act == ACT_MOV && $urandom_range(0, 1)) begin
        send(act, 5'($urandom()), 5'($urandom()), rand_value(), len);
      end else begin
        send(act, 5'($urandom()), 5'($urandom()),
             ($urandom_range(0, 1) ? 64'($urandom_range(0, 200)) : rand_value()), len);
      end
    end
    drain();
  endtask

  initial begin
    logic [31:0] psize;
    in_valid = 1'b0;
    action = '0;
    dest_reg = '0;
    src_reg = '0;
    jump_target = '0;
    instr_length = 4'd1;
    cfg_we = 1'b0;
    cfg_index = CFG_PROGRAM_SIZE;
    cfg_data = '0;
    requests_sent = 0;
    rst = 1'b1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: seed registers through mov of loaded values via pointer
    write_cfg(CFG_PROGRAM_SIZE, 32'd20);
    write_cfg(CFG_START_ADDRESS, 32'd0);
    send(ACT_INC, 5'd1, 5'd0, '0, 4'd1);
    send(ACT_DEC, 5'd2, 5'd0, '0, 4'd9);
    send(ACT_MOV, 5'd3, 5'd17, '0, 4'd2);
    send(ACT_MUL, 5'd2, 5'd2, '0, 4'd3);
    send(ACT_DIV, 5'd2, 5'd3, '0, 4'd3);
    send(ACT_DIV, 5'd2, 5'd0, '0, 4'd3);
    send(ACT_ADD, 5'd4, 5'd2, '0, 4'd0);
    send(ACT_SUB, 5'd5, 5'd1, '0, 4'd15);
    send(ACT_AND, 5'd4, 5'd3, '0, 4'd1);
    send(ACT_OR, 5'd5, 5'd3, '0, 4'd1);
    send(ACT_XOR, 5'd6, 5'd2, '0, 4'd1);
    send(ACT_CMP, 5'd0, 5'd1, '0, 4'd1);
    send(ACT_LT, 5'd0, 5'd0, '0, 4'd1);
    send(ACT_MT, 5'd0, 5'd0, '0, 4'd1);
    send(ACT_LET, 5'd0, 5'd0, '0, 4'd1);
    send(ACT_MET, 5'd0, 5'd0, '0, 4'd1);
    send(ACT_ET, 5'd0, 5'd0, '0, 4'd1);
    send(ACT_JE, 5'd0, 5'd0, 64'd20, 4'd1);
    send(ACT_JZL, 5'd0, 5'd0, '1, 4'd1);
    send(ACT_JZR, 5'd0, 5'd0, 64'd5, 4'd1);
    send(ACT_JZLE, 5'd0, 5'd0, 64'd7, 4'd1);
    send(ACT_JZRE, 5'd0, 5'd0, 64'd9, 4'd1);
    send(ACT_JNE, 5'd0, 5'd0, 64'd11, 4'd1);
    send(ACT_JMP, 5'd0, 5'd0, 64'd20, 4'd1);
    send(ACT_INC, 5'd17, 5'd0, '0, 4'd1);
    send(5'd31, 5'd0, 5'd0, '0, 4'd1);
    send(ACT_NOP, 5'd0, 5'd0, '0, 4'd1);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: psize = 32'hffff_ffff;
        1: psize = 32'd0;
        default: psize = 32'($urandom_range(0, 300));
      endcase
      write_cfg(CFG_PROGRAM_SIZE, psize);
      write_cfg(CFG_START_ADDRESS, (phase == 0) ? 32'hffff_ffff :
                                   (phase == 1) ? 32'd0 : 32'($urandom_range(0, 100)));
      random_phase(100);
    end

    $display("sent %0d instruction requests and checked %0d results over 9 settings",
             requests_sent, results_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+src
src/rvm_exec_pkg.sv
src/register_vm_execute_core_top.sv
bench/register_vm_execute_core_checker.sv
bench/register_vm_execute_core_top_test.sv
